FILE: hw/rtl/rpf_pkg.sv
// Shared types and constants of the relay pulse and flash controller.
`default_nettype none

package rpf_pkg;

  localparam int TIME_BITS_DEF = 24;
  localparam int DATA_W        = 32;
  localparam int ADDR_W        = 5;
  localparam int REG_IDX_W     = 3;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_SET    = 2'd1,
    ACT_TOGGLE = 2'd2,
    ACT_FLASH  = 2'd3
  } action_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PULSE_MS        = 3'd0,
    REG_BASE_STATE      = 3'd1,
    REG_RELAY_INVERT    = 3'd2,
    REG_FOLLOWER_ENABLE = 3'd3,
    REG_FOLLOWER_INVERT = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic base_state;
    logic relay_invert;
    logic follower_enable;
    logic follower_invert;
  } cfg_flags_t;

  typedef struct packed {
    logic pin_level;
    logic relay_on;
    logic follower_level;
    logic timer_active;
    logic flashing;
  } result_t;

endpackage : rpf_pkg

`default_nettype wire

FILE: hw/rtl/rpf_cfg.sv
// APB register file holding the pulse duration and the option flags.
`default_nettype none

module rpf_cfg #(
  parameter int TIME_BITS = rpf_pkg::TIME_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rpf_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [rpf_pkg::DATA_W-1:0]    pwdata,
  output logic      [rpf_pkg::DATA_W-1:0]    prdata,
  output logic                               pready,
  output logic      [TIME_BITS-1:0]          pulse_ms,
  output rpf_pkg::cfg_flags_t                flags
);

  logic [TIME_BITS-1:0]      pulse_ms_r;
  rpf_pkg::cfg_flags_t       flags_r;
  rpf_pkg::reg_idx_t         idx;
  logic                      wr_en;

  assign idx    = rpf_pkg::reg_idx_t'(paddr[rpf_pkg::ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_ms_r <= '0;
      flags_r    <= '0;
    end else if (wr_en) begin
      case (idx)
        rpf_pkg::REG_PULSE_MS:        pulse_ms_r              <= pwdata[TIME_BITS-1:0];
        rpf_pkg::REG_BASE_STATE:      flags_r.base_state      <= pwdata[0];
        rpf_pkg::REG_RELAY_INVERT:    flags_r.relay_invert    <= pwdata[0];
        rpf_pkg::REG_FOLLOWER_ENABLE: flags_r.follower_enable <= pwdata[0];
        rpf_pkg::REG_FOLLOWER_INVERT: flags_r.follower_invert <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      rpf_pkg::REG_PULSE_MS:        prdata[TIME_BITS-1:0] = pulse_ms_r;
      rpf_pkg::REG_BASE_STATE:      prdata[0] = flags_r.base_state;
      rpf_pkg::REG_RELAY_INVERT:    prdata[0] = flags_r.relay_invert;
      rpf_pkg::REG_FOLLOWER_ENABLE: prdata[0] = flags_r.follower_enable;
      rpf_pkg::REG_FOLLOWER_INVERT: prdata[0] = flags_r.follower_invert;
      default:                      prdata = '0;
    endcase
  end

  assign pulse_ms = pulse_ms_r;
  assign flags    = flags_r;

endmodule : rpf_cfg

`default_nettype wire

FILE: hw/rtl/rpf_step.sv
// Next-state and result logic for one request.
`default_nettype none

module rpf_step #(
  parameter int TIME_BITS = rpf_pkg::TIME_BITS_DEF
) (
  input  wire rpf_pkg::action_t       action,
  input  wire logic                   state_value,
  input  wire logic [TIME_BITS-1:0]   duration,
  input  wire logic [TIME_BITS-1:0]   pulse_ms,
  input  wire rpf_pkg::cfg_flags_t    flags,
  input  wire logic                   pin_cur,
  input  wire logic [TIME_BITS:0]     rest_rem_cur,
  input  wire logic                   rest_lvl_cur,
  input  wire logic [TIME_BITS-1:0]   fl_per_cur,
  input  wire logic [TIME_BITS+1:0]   fl_rem_cur,
  output logic                        pin_nxt,
  output logic      [TIME_BITS:0]     rest_rem_nxt,
  output logic                        rest_lvl_nxt,
  output logic      [TIME_BITS-1:0]   fl_per_nxt,
  output logic      [TIME_BITS+1:0]   fl_rem_nxt,
  output rpf_pkg::result_t            result
);

  // Drive a logical level and maybe arm the restore (shared by all commands).
  logic                 cmd_lvl;
  logic [TIME_BITS-1:0] cmd_dur;
  logic                 cmd_en;
  logic [TIME_BITS-1:0] eff_dur;
  logic                 pin_mid;
  logic [TIME_BITS:0]   rest_mid;
  logic [TIME_BITS+1:0] fl_dec;
  logic                 logical;

  assign eff_dur = (cmd_dur == '0) ? pulse_ms : cmd_dur;

  always_comb begin
    pin_mid    = pin_cur;
    rest_mid   = rest_rem_cur;
    fl_per_nxt = fl_per_cur;
    fl_rem_nxt = fl_rem_cur;
    fl_dec     = '0;
    cmd_en     = 1'b0;
    cmd_lvl    = 1'b0;
    cmd_dur    = duration;

    case (action)
      rpf_pkg::ACT_TICK: begin
        // Restore countdown first; it may drive the pin before the flash toggle.
        if (rest_rem_cur != '0) begin
          rest_mid = rest_rem_cur - 1'b1;
          if (rest_mid == '0) begin
            pin_mid = rest_lvl_cur ^ flags.relay_invert;
          end
        end
        if (fl_per_cur != '0) begin
          fl_dec = (fl_rem_cur != '0) ? fl_rem_cur - 1'b1 : fl_rem_cur;
          fl_rem_nxt = fl_dec;
          if (fl_dec == '0) begin
            cmd_en     = 1'b1;
            cmd_lvl    = ~(pin_mid ^ flags.relay_invert);
            cmd_dur    = fl_per_cur;
            fl_rem_nxt = {1'b0, fl_per_cur, 1'b1};
          end
        end
      end
      rpf_pkg::ACT_SET: begin
        fl_per_nxt = '0;
        cmd_en     = 1'b1;
        cmd_lvl    = state_value;
      end
      rpf_pkg::ACT_TOGGLE: begin
        fl_per_nxt = '0;
        cmd_en     = 1'b1;
        cmd_lvl    = ~(pin_cur ^ flags.relay_invert);
      end
      rpf_pkg::ACT_FLASH: begin
        if (duration == '0) begin
          fl_per_nxt = '0;
        end else begin
          fl_per_nxt = duration;
          fl_rem_nxt = {1'b0, duration, 1'b1};
          cmd_en     = 1'b1;
          cmd_lvl    = ~(pin_cur ^ flags.relay_invert);
        end
      end
      default: ;
    endcase

    pin_nxt      = pin_mid;
    rest_rem_nxt = rest_mid;
    rest_lvl_nxt = rest_lvl_cur;
    if (cmd_en) begin
      pin_nxt = cmd_lvl ^ flags.relay_invert;
      if (eff_dur != '0) begin
        rest_lvl_nxt = (pulse_ms != '0) ? flags.base_state : ~cmd_lvl;
        rest_rem_nxt = {1'b0, eff_dur} + 1'b1;
      end
    end
  end

  assign logical               = pin_nxt ^ flags.relay_invert;
  assign result.pin_level      = pin_nxt;
  assign result.relay_on       = logical;
  assign result.follower_level = flags.follower_enable & (logical ^ flags.follower_invert);
  assign result.timer_active   = (rest_rem_nxt != '0);
  assign result.flashing       = (fl_per_nxt != '0);

endmodule : rpf_step

`default_nettype wire

FILE: hw/rtl/relay_pulse_flash_controller.sv
// Top level of the relay pulse and flash controller.
`default_nettype none

// Channel   Direction  Handshake            Payload
// in_       request    in_valid / in_stall  in_action, in_state_value, in_duration
// out_      result     out_valid/out_stall  out_pin_level, out_relay_on,
//                                           out_follower_level, out_timer_active,
//                                           out_flashing
// cfg       APB write  psel/penable/pready  paddr, pwdata, prdata
//
// For every request, the state update and the result are
// computed in one pass of rpf_step and captured at the accepting edge.
// A request is accepted in every cycle unless a result is waiting in the
// output register and the receiver stalls it.
// The synchronous reset clears the relay state, both countdowns, flash mode,
// all configuration registers and the output valid flag.
// The result shows the state after its request; a tick handles the momentary
// restore before the flash countdown, so both may act in the same millisecond.

module relay_pulse_flash_controller #(
  parameter int TIME_BITS = rpf_pkg::TIME_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // request channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  in_action,
  input  wire logic                        in_state_value,
  input  wire logic [TIME_BITS-1:0]        in_duration,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_pin_level,
  output logic                             out_relay_on,
  output logic                             out_follower_level,
  output logic                             out_timer_active,
  output logic                             out_flashing,
  // configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [rpf_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [rpf_pkg::DATA_W-1:0]  pwdata,
  output logic      [rpf_pkg::DATA_W-1:0]  prdata,
  output logic                             pready
);

  logic [TIME_BITS-1:0]  pulse_ms;
  rpf_pkg::cfg_flags_t   flags;

  // Relay state.
  logic                  pin_r, pin_nxt;
  logic [TIME_BITS:0]    rest_rem_r, rest_rem_nxt;
  logic                  rest_lvl_r, rest_lvl_nxt;
  logic [TIME_BITS-1:0]  fl_per_r, fl_per_nxt;
  logic [TIME_BITS+1:0]  fl_rem_r, fl_rem_nxt;

  // Output register.
  logic                  out_valid_r;
  rpf_pkg::result_t      res_r, res_nxt;

  logic                  in_acc;

  rpf_cfg #(
    .TIME_BITS (TIME_BITS)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .pulse_ms (pulse_ms),
    .flags    (flags)
  );

  rpf_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .action       (rpf_pkg::action_t'(in_action)),
    .state_value  (in_state_value),
    .duration     (in_duration),
    .pulse_ms     (pulse_ms),
    .flags        (flags),
    .pin_cur      (pin_r),
    .rest_rem_cur (rest_rem_r),
    .rest_lvl_cur (rest_lvl_r),
    .fl_per_cur   (fl_per_r),
    .fl_rem_cur   (fl_rem_r),
    .pin_nxt      (pin_nxt),
    .rest_rem_nxt (rest_rem_nxt),
    .rest_lvl_nxt (rest_lvl_nxt),
    .fl_per_nxt   (fl_per_nxt),
    .fl_rem_nxt   (fl_rem_nxt),
    .result       (res_nxt)
  );

  // The output register is the only buffer; it frees up as soon as the
  // waiting result is taken, so a new request can enter in the same cycle.
  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_r      <= 1'b0;
      rest_rem_r <= '0;
      rest_lvl_r <= 1'b0;
      fl_per_r   <= '0;
      fl_rem_r   <= '0;
    end else if (in_acc) begin
      pin_r      <= pin_nxt;
      rest_rem_r <= rest_rem_nxt;
      rest_lvl_r <= rest_lvl_nxt;
      fl_per_r   <= fl_per_nxt;
      fl_rem_r   <= fl_rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pin_level      = res_r.pin_level;
  assign out_relay_on       = res_r.relay_on;
  assign out_follower_level = res_r.follower_level;
  assign out_timer_active   = res_r.timer_active;
  assign out_flashing       = res_r.flashing;

  // While flashing, the flash countdown is reloaded before it can sit at zero.
  a_flash_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    (fl_per_r != '0) |-> (fl_rem_r != '0))
    else $error("flash running with empty countdown");

  // Every accepted request shows up as a pending result at the next edge.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted request produced no result");

  // The reported timer and flash flags match the state that was stored.
  a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> ((out_timer_active == (rest_rem_r != '0))
                && (out_flashing == (fl_per_r != '0))))
    else $error("result flags disagree with stored state");

endmodule : relay_pulse_flash_controller

`default_nettype wire

FILE: verif/tb_relay_pulse_flash_controller.sv
// Self-checking testbench for the relay pulse and flash controller.
`timescale 1ns / 1ps

module tb_relay_pulse_flash_controller;

  // The flash reload is this many periods plus one tick.
  localparam int FLASH_MULT = 2;
  localparam logic [23:0] DUR_MAX = 24'hFFFFFF;

  logic clk = 1'b0;
  logic rst_n;

  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_action;
  logic        in_state_value;
  logic [23:0] in_duration;

  logic out_valid;
  logic out_stall;
  logic out_pin_level;
  logic out_relay_on;
  logic out_follower_level;
  logic out_timer_active;
  logic out_flashing;

  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [rpf_pkg::ADDR_W-1:0] paddr;
  logic [rpf_pkg::DATA_W-1:0] pwdata;
  logic [rpf_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  relay_pulse_flash_controller dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_state_value    (in_state_value),
    .in_duration       (in_duration),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pin_level     (out_pin_level),
    .out_relay_on      (out_relay_on),
    .out_follower_level(out_follower_level),
    .out_timer_active  (out_timer_active),
    .out_flashing      (out_flashing),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // 10 ns clock. Inputs are driven on the falling edge and outputs are
  // sampled on the rising edge, so nothing depends on event ordering.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle percentages for the two sides of the data path, changed per phase.
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  // A nonzero value asks the stall generator for one long hold-off.
  int hold_off_len    = 0;
  int items_sent      = 0;
  int mismatch_count  = 0;

  // Mirror of the configuration registers, updated at each APB write.
  logic [23:0] cfg_pulse_ms        = '0;
  logic        cfg_base_state      = 1'b0;
  logic        cfg_relay_invert    = 1'b0;
  logic        cfg_follower_enable = 1'b0;
  logic        cfg_follower_invert = 1'b0;

  // Predicted relay state. The restore countdown needs one bit beyond the
  // duration, the flash countdown two.
  logic        relay_pin_q     = 1'b0;
  logic [24:0] restore_left_q  = '0;
  logic        restore_level_q = 1'b0;
  logic [23:0] flash_period_q  = '0;
  logic [25:0] flash_left_q    = '0;

  // Status words predicted for requests accepted so far, oldest first.
  rpf_pkg::result_t expected_status_q[$];

  // ---------------------------------------------------------------------
  // Relay state predictor
  // ---------------------------------------------------------------------

  function automatic void drive_pin(logic level);
    relay_pin_q = level ^ cfg_relay_invert;
  endfunction

  // Drives a new logical level and arms the momentary restore. A zero
  // duration falls back to the default pulse; if that is zero too, nothing
  // is armed and a pending restore is left exactly as it was.
  function automatic void arm_relay(logic level, logic [23:0] dur);
    logic [23:0] span;
    span = (dur == '0) ? cfg_pulse_ms : dur;
    if (span != '0) begin
      // With pulse mode on, the restore goes to the base level; without it,
      // the restore goes back to the opposite of the level just driven.
      restore_level_q = (cfg_pulse_ms != '0) ? cfg_base_state : ~level;
      restore_left_q  = {1'b0, span} + 25'd1;
    end
    drive_pin(level);
  endfunction

  function automatic void flip_relay(logic [23:0] dur);
    arm_relay(~(relay_pin_q ^ cfg_relay_invert), dur);
  endfunction

  function automatic logic [25:0] flash_reload(logic [23:0] period);
    return 26'(period) * 26'(FLASH_MULT) + 26'd1;
  endfunction

  function automatic rpf_pkg::result_t step_relay_model(rpf_pkg::action_t act,
                                                        logic level,
                                                        logic [23:0] dur);
    rpf_pkg::result_t res;
    logic             logical;
    case (act)
      rpf_pkg::ACT_TICK: begin
        // The restore is handled before the flash within the same tick.
        if (restore_left_q != '0) begin
          restore_left_q = restore_left_q - 25'd1;
          if (restore_left_q == '0) drive_pin(restore_level_q);
        end
        if (flash_period_q != '0) begin
          if (flash_left_q != '0) flash_left_q = flash_left_q - 26'd1;
          if (flash_left_q == '0) begin
            flip_relay(flash_period_q);
            flash_left_q = flash_reload(flash_period_q);
          end
        end
      end
      rpf_pkg::ACT_SET: begin
        flash_period_q = '0;
        arm_relay(level, dur);
      end
      rpf_pkg::ACT_TOGGLE: begin
        flash_period_q = '0;
        flip_relay(dur);
      end
      default: begin
        // A zero period only stops flashing; relay and restore stay as is.
        if (dur == '0) begin
          flash_period_q = '0;
        end else begin
          flash_period_q = dur;
          flash_left_q   = flash_reload(dur);
          flip_relay(dur);
        end
      end
    endcase
    logical            = relay_pin_q ^ cfg_relay_invert;
    res.pin_level      = relay_pin_q;
    res.relay_on       = logical;
    res.follower_level = cfg_follower_enable ? (logical ^ cfg_follower_invert) : 1'b0;
    res.timer_active   = (restore_left_q != '0);
    res.flashing       = (flash_period_q != '0);
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------

  task automatic check_field(string field, logic want, logic got);
    if (got !== want) begin
      $error("%s: expected %0b, got %0b", field, want, got);
      mismatch_count++;
    end
  endtask

  // Every accepted result is compared with the oldest prediction.
  always @(posedge clk) begin : result_check
    rpf_pkg::result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_status_q.size() == 0) begin
        $error("result arrived with no request outstanding");
        mismatch_count++;
      end else begin
        want = expected_status_q.pop_front();
        check_field("pin_level", want.pin_level, out_pin_level);
        check_field("relay_on", want.relay_on, out_relay_on);
        check_field("follower_level", want.follower_level, out_follower_level);
        check_field("timer_active", want.timer_active, out_timer_active);
        check_field("flashing", want.flashing, out_flashing);
      end
    end
  end

  // Receiver stall generator. A hold-off request keeps the result channel
  // stalled for the whole stretch, counted here one falling edge at a time.
  initial begin : result_stall_gen
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_len != 0) begin
        n = hold_off_len;
        hold_off_len = 0;
        out_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Drivers. Every task starts and ends just after a falling edge.
  // ---------------------------------------------------------------------

  // Offers one request, holds it while stalled, and records the prediction
  // at the accepting edge. Valid stays high on return so that back-to-back
  // requests never see valid dropped and raised in the same step.
  task automatic send_request(rpf_pkg::action_t act, logic level, logic [23:0] dur);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= act;
    in_state_value <= level;
    in_duration    <= dur;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_status_q.push_back(step_relay_model(act, level, dur));
    items_sent++;
    @(negedge clk);
  endtask

  // Ticks carry random filler in the fields they ignore.
  task automatic send_ticks(int count);
    repeat (count) send_request(rpf_pkg::ACT_TICK, 1'($urandom_range(1)), 24'($urandom));
  endtask

  // Stops offering requests and waits until every result has been taken.
  // Each request yields a result, so the block is idle once the queue drains.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_status_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Two-phase APB write: setup, then access; the register takes the data at
  // the rising edge with psel, penable, pwrite and pready all high.
  task automatic apb_write(rpf_pkg::reg_idx_t idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      rpf_pkg::REG_PULSE_MS:        cfg_pulse_ms        = value[23:0];
      rpf_pkg::REG_BASE_STATE:      cfg_base_state      = value[0];
      rpf_pkg::REG_RELAY_INVERT:    cfg_relay_invert    = value[0];
      rpf_pkg::REG_FOLLOWER_ENABLE: cfg_follower_enable = value[0];
      rpf_pkg::REG_FOLLOWER_INVERT: cfg_follower_invert = value[0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_idling(int sender_pct, int recv_pct);
    sender_idle_pct = sender_pct;
    recv_stall_pct  = recv_pct;
  endtask

  // Mostly short durations so restores and flash toggles actually fire;
  // zero and the maximum are common, and full-width values exercise every bit.
  function automatic logic [23:0] pick_duration();
    int pick;
    pick = $urandom_range(99);
    if (pick < 25) return '0;
    if (pick < 80) return 24'($urandom_range(1, 5));
    if (pick < 90) return DUR_MAX;
    return 24'($urandom);
  endfunction

  // Most sequences are a command followed by a run of ticks long enough to
  // reach the restore and a few flash toggles; the rest are lone random
  // requests that cut into whatever is running.
  task automatic send_sequence();
    int               pick;
    rpf_pkg::action_t cmd;
    pick = $urandom_range(99);
    if (pick < 12) begin
      send_request(rpf_pkg::action_t'($urandom_range(3)), 1'($urandom_range(1)),
                   24'($urandom));
    end else begin
      cmd = rpf_pkg::action_t'($urandom_range(rpf_pkg::ACT_SET, rpf_pkg::ACT_FLASH));
      send_request(cmd, 1'($urandom_range(1)), pick_duration());
      send_ticks($urandom_range(14));
    end
  endtask

  task automatic randomize_config();
    logic [23:0] pulse;
    case ($urandom_range(4))
      0:       pulse = '0;
      1:       pulse = DUR_MAX;
      4:       pulse = 24'($urandom);
      default: pulse = 24'($urandom_range(1, 6));
    endcase
    apb_write(rpf_pkg::REG_PULSE_MS, 32'(pulse));
    apb_write(rpf_pkg::REG_BASE_STATE, 32'($urandom_range(1)));
    apb_write(rpf_pkg::REG_RELAY_INVERT, 32'($urandom_range(1)));
    apb_write(rpf_pkg::REG_FOLLOWER_ENABLE, 32'($urandom_range(1)));
    apb_write(rpf_pkg::REG_FOLLOWER_INVERT, 32'($urandom_range(1)));
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset configuration: pulse mode off, no inversion, follower disabled.
  task automatic test_directed_commands();
    send_ticks(1);                                     // nothing armed, nothing moves
    send_request(rpf_pkg::ACT_SET, 1'b1, '0);          // set with no pulse: no restore
    send_request(rpf_pkg::ACT_TOGGLE, 1'b0, '0);
    send_request(rpf_pkg::ACT_SET, 1'b1, 24'd2);       // restore to 0 on the third tick
    send_ticks(3);
    send_request(rpf_pkg::ACT_SET, 1'b1, 24'd3);
    send_ticks(1);
    send_request(rpf_pkg::ACT_SET, 1'b0, '0);          // pending restore stays armed
    send_ticks(3);
    send_request(rpf_pkg::ACT_FLASH, 1'b0, 24'd1);     // toggles now, restore and flash race
    send_ticks(3);                                     // flash toggles on the third tick
    send_request(rpf_pkg::ACT_FLASH, 1'b1, '0);        // stop flashing, relay untouched
    send_request(rpf_pkg::ACT_TOGGLE, 1'b1, DUR_MAX);
    send_request(rpf_pkg::ACT_SET, 1'b0, DUR_MAX);
    send_request(rpf_pkg::ACT_FLASH, 1'b1, DUR_MAX);
    send_request(rpf_pkg::ACT_SET, 1'b1, 24'd1);       // set also stops the flash
    send_ticks(2);
  endtask

  // Pulse mode: the restore goes to the base level, and a zero duration
  // takes the default pulse, including the largest one.
  task automatic test_pulse_mode();
    logic [23:0] pulses[4];
    int          goal;
    pulses = '{24'd1, 24'd3, DUR_MAX, 24'($urandom_range(2, 9))};
    foreach (pulses[i]) begin
      for (int base = 0; base < 2; base++) begin
        wait_idle();
        apb_write(rpf_pkg::REG_PULSE_MS, 32'(pulses[i]));
        apb_write(rpf_pkg::REG_BASE_STATE, 32'(base));
        goal = items_sent + 25;
        while (items_sent < goal) send_sequence();
      end
    end
  endtask

  // Every combination of relay inversion and follower options.
  task automatic test_output_options();
    int goal;
    for (int combo = 0; combo < 8; combo++) begin
      wait_idle();
      apb_write(rpf_pkg::REG_RELAY_INVERT, 32'(combo[0]));
      apb_write(rpf_pkg::REG_FOLLOWER_ENABLE, 32'(combo[1]));
      apb_write(rpf_pkg::REG_FOLLOWER_INVERT, 32'(combo[2]));
      goal = items_sent + 20;
      while (items_sent < goal) send_sequence();
    end
  endtask

  // Random traffic in blocks, with a fresh configuration before each block.
  task automatic test_random_traffic(int count);
    int goal;
    int block_end;
    goal = items_sent + count;
    while (items_sent < goal) begin
      wait_idle();
      randomize_config();
      block_end = items_sent + 90;
      while (items_sent < block_end && items_sent < goal) send_sequence();
    end
  endtask

  // The receiver holds off for a long stretch while requests keep coming,
  // so the output register fills and the input stalls; then the sender
  // pauses until everything outstanding has come back.
  task automatic test_backpressure();
    set_idling(0, 0);
    repeat (2) begin
      wait_idle();
      hold_off_len = 60;
      repeat (12) send_sequence();
      wait_idle();
    end
  endtask

  // Hard limit on the run in case the block hangs.
  initial begin
    #5_000_000;
    $display("** relay_pulse_flash_controller: FAILED **");
    $finish;
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_action      = rpf_pkg::ACT_TICK;
    in_state_value = 1'b0;
    in_duration    = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Sender idles rarely and the receiver stalls often.
    set_idling(23, 78);
    test_directed_commands();
    test_pulse_mode();
    test_output_options();
    test_random_traffic(180);

    // Roles reversed: the sender is sparse and the receiver mostly ready.
    set_idling(78, 23);
    test_random_traffic(280);

    // Full rate, with deliberate long hold-offs first.
    test_backpressure();
    set_idling(0, 0);
    test_random_traffic(230);

    wait_idle();
    repeat (5) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("** relay_pulse_flash_controller: PASSED **");
    end else begin
      $display("** relay_pulse_flash_controller: FAILED **");
    end
    $finish;
  end

endmodule
